// ===== rtl/rgb_to_hsv_pixel_defines.svh =====
// ----------------------------------------------------------------------------
// rgb_to_hsv_pixel_defines
// assertion macros shared by the rgb to hsv pixel converter
// ----------------------------------------------------------------------------
`ifndef RGB_TO_HSV_PIXEL_DEFINES_SVH
`define RGB_TO_HSV_PIXEL_DEFINES_SVH

// same-cycle implication, checked outside reset
`define RHSV_ASSERT_IMPLIES(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked outside reset
`define RHSV_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/rhsv_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rhsv_pkg
// widths and default fraction settings of the rgb to hsv pixel converter
// ----------------------------------------------------------------------------
package rhsv_pkg;

  localparam int unsigned RGB_W = 8;
  localparam int unsigned HUE_W = 15;
  localparam int unsigned SAT_W = 13;
  localparam int unsigned VAL_W = 8;

  // 60 * hue sector numerator stays below 360 * 255
  localparam int unsigned NUM60_W = 17;

  localparam int unsigned HUE_FRAC_BITS_DEF = 6;
  localparam int unsigned SAT_FRAC_BITS_DEF = 12;

endpackage

// ===== rtl/rgb_to_hsv_pixel.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rgb_to_hsv_pixel
// 8-bit rgb pixel to fixed-point hue, saturation and value
// ----------------------------------------------------------------------------
// input channel: in_valid_i / in_ready_o with red_i, green_i, blue_i.
// output channel: out_valid_o / out_ready_i with hue_q6_o (hue degrees
// scaled by 2^HUE_FRAC_BITS), saturation_q12_o (scaled by 2^SAT_FRAC_BITS)
// and value_max_o (largest channel).
// a front stage finds max, min and the hue numerator; a row of STEPS
// identical division cells then produces one quotient bit of hue and of
// saturation per cell, STEPS = max(17 + HUE_FRAC_BITS, 8 + SAT_FRAC_BITS).
// items are registered in the front stage and then in each cell; throughput,
// while out_ready_i is high, is one item per cycle, set by the division row.
// each stage holds its item while the next one is full, so bubbles close up
// when the receiver stalls; in_ready_o drops only once every stage is full.
// reset empties the row, dropping items in flight; none is emitted across reset.
// grey pixels give hue 0, black pixels give saturation 0.
// ----------------------------------------------------------------------------
`include "rgb_to_hsv_pixel_defines.svh"

module rgb_to_hsv_pixel import rhsv_pkg::*; #(
  parameter int unsigned HUE_FRAC_BITS = HUE_FRAC_BITS_DEF,
  parameter int unsigned SAT_FRAC_BITS = SAT_FRAC_BITS_DEF
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  logic [RGB_W-1:0] red_i,
  input  logic [RGB_W-1:0] green_i,
  input  logic [RGB_W-1:0] blue_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output logic [HUE_W-1:0] hue_q6_o,
  output logic [SAT_W-1:0] saturation_q12_o,
  output logic [VAL_W-1:0] value_max_o
);

  localparam int unsigned HUE_N_W = NUM60_W + HUE_FRAC_BITS;
  localparam int unsigned SAT_N_W = RGB_W + SAT_FRAC_BITS;
  localparam int unsigned STEPS   = (HUE_N_W > SAT_N_W) ? HUE_N_W : SAT_N_W;

  logic             vld [STEPS+1];
  logic             rdy [STEPS+1];
  logic [RGB_W-1:0] hue_rem [STEPS+1];
  logic [RGB_W-1:0] hue_div [STEPS+1];
  logic [STEPS-1:0] hue_num [STEPS+1];
  logic [RGB_W-1:0] sat_rem [STEPS+1];
  logic [RGB_W-1:0] sat_div [STEPS+1];
  logic [STEPS-1:0] sat_num [STEPS+1];

  rhsv_front #(
    .HueFracBits (HUE_FRAC_BITS),
    .SatFracBits (SAT_FRAC_BITS),
    .NumW        (STEPS)
  ) u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .valid_i   (in_valid_i),
    .ready_o   (in_ready_o),
    .red_i     (red_i),
    .green_i   (green_i),
    .blue_i    (blue_i),
    .valid_o   (vld[0]),
    .ready_i   (rdy[0]),
    .hue_num_o (hue_num[0]),
    .hue_div_o (hue_div[0]),
    .sat_num_o (sat_num[0]),
    .sat_div_o (sat_div[0])
  );

  // partial remainders start at zero
  assign hue_rem[0] = '0;
  assign sat_rem[0] = '0;

  for (genvar k = 0; k < STEPS; k++) begin : g_cell
    rhsv_div_cell #(
      .NumW (STEPS)
    ) u_cell (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .valid_i   (vld[k]),
      .ready_o   (rdy[k]),
      .hue_rem_i (hue_rem[k]),
      .hue_div_i (hue_div[k]),
      .hue_num_i (hue_num[k]),
      .sat_rem_i (sat_rem[k]),
      .sat_div_i (sat_div[k]),
      .sat_num_i (sat_num[k]),
      .valid_o   (vld[k+1]),
      .ready_i   (rdy[k+1]),
      .hue_rem_o (hue_rem[k+1]),
      .hue_div_o (hue_div[k+1]),
      .hue_num_o (hue_num[k+1]),
      .sat_rem_o (sat_rem[k+1]),
      .sat_div_o (sat_div[k+1]),
      .sat_num_o (sat_num[k+1])
    );
  end

  assign rdy[STEPS]  = out_ready_i;
  assign out_valid_o = vld[STEPS];

  // a zero divisor means grey (hue) or black (saturation)
  assign hue_q6_o         = (hue_div[STEPS] == '0) ? '0 : hue_num[STEPS][HUE_W-1:0];
  assign saturation_q12_o = (sat_div[STEPS] == '0) ? '0 : sat_num[STEPS][SAT_W-1:0];
  assign value_max_o      = sat_div[STEPS];

  `RHSV_ASSERT_IMPLIES(a_full_row_on_stall, !in_ready_o,
    out_valid_o && !out_ready_i, "input stalled while the row has room")
  `RHSV_ASSERT_NEXT(a_accept_fills_front, in_valid_i && in_ready_o,
    vld[0], "accepted item missing from front stage")
  `RHSV_ASSERT_IMPLIES(a_hue_rem_bound, out_valid_o && (hue_div[STEPS] != '0),
    hue_rem[STEPS] < hue_div[STEPS], "hue remainder not below divisor")
  `RHSV_ASSERT_IMPLIES(a_sat_rem_bound, out_valid_o && (sat_div[STEPS] != '0),
    sat_rem[STEPS] < sat_div[STEPS], "saturation remainder not below divisor")

endmodule

// ===== rtl/rhsv_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rhsv_front
// max / min search, hue sector numerator and dividend setup for both dividers
// ----------------------------------------------------------------------------
module rhsv_front import rhsv_pkg::*; #(
  parameter int unsigned HueFracBits = HUE_FRAC_BITS_DEF,
  parameter int unsigned SatFracBits = SAT_FRAC_BITS_DEF,
  parameter int unsigned NumW        = NUM60_W + HUE_FRAC_BITS_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              valid_i,
  output logic              ready_o,
  input  logic [RGB_W-1:0]  red_i,
  input  logic [RGB_W-1:0]  green_i,
  input  logic [RGB_W-1:0]  blue_i,
  output logic              valid_o,
  input  logic              ready_i,
  output logic [NumW-1:0]   hue_num_o,
  output logic [RGB_W-1:0]  hue_div_o,
  output logic [NumW-1:0]   sat_num_o,
  output logic [RGB_W-1:0]  sat_div_o
);

  localparam int unsigned T_W = 12;

  logic             valid_q;
  logic [NumW-1:0]  hue_num_q, hue_num_d;
  logic [RGB_W-1:0] hue_div_q, hue_div_d;
  logic [NumW-1:0]  sat_num_q, sat_num_d;
  logic [RGB_W-1:0] sat_div_q, sat_div_d;

  logic             red_dom, green_dom;
  logic [RGB_W-1:0] mx, mn, dd;
  logic signed [T_W-1:0] diff_s, base_s, t_s, wrap_s;
  logic [10:0]      t_u;
  logic [NUM60_W-1:0] num60;

  always_comb begin
    red_dom   = (red_i >= green_i) && (red_i >= blue_i);
    green_dom = (green_i >= red_i) && (green_i >= blue_i);

    mx = red_i;
    if (green_i > mx) mx = green_i;
    if (blue_i > mx) mx = blue_i;
    mn = red_i;
    if (green_i < mn) mn = green_i;
    if (blue_i < mn) mn = blue_i;
    dd = mx - mn;

    // sector offset in units of d: 0, 2 or 4
    if (red_dom) begin
      diff_s = $signed(T_W'(green_i)) - $signed(T_W'(blue_i));
      base_s = '0;
    end else if (green_dom) begin
      diff_s = $signed(T_W'(blue_i)) - $signed(T_W'(red_i));
      base_s = $signed(T_W'(dd) << 1);
    end else begin
      diff_s = $signed(T_W'(red_i)) - $signed(T_W'(green_i));
      base_s = $signed(T_W'(dd) << 2);
    end
    t_s = base_s + diff_s;

    // negative hue wraps by a full turn, six sectors of d
    wrap_s = $signed((T_W'(dd) << 2) + (T_W'(dd) << 1));
    if (t_s < 0) t_s = t_s + wrap_s;
    t_u = t_s[10:0];

    num60 = (NUM60_W'(t_u) << 6) - (NUM60_W'(t_u) << 2);

    hue_num_d = NumW'(num60) << HueFracBits;
    hue_div_d = dd;
    sat_num_d = NumW'(dd) << SatFracBits;
    sat_div_d = mx;
  end

  assign ready_o = !valid_q || ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i && ready_o) begin
      hue_num_q <= hue_num_d;
      hue_div_q <= hue_div_d;
      sat_num_q <= sat_num_d;
      sat_div_q <= sat_div_d;
    end
  end

  assign valid_o   = valid_q;
  assign hue_num_o = hue_num_q;
  assign hue_div_o = hue_div_q;
  assign sat_num_o = sat_num_q;
  assign sat_div_o = sat_div_q;

endmodule

// ===== rtl/rhsv_div_cell.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rhsv_div_cell
// one restoring division step for the hue and the saturation quotient
// ----------------------------------------------------------------------------
module rhsv_div_cell import rhsv_pkg::*; #(
  parameter int unsigned NumW = NUM60_W + HUE_FRAC_BITS_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              valid_i,
  output logic              ready_o,
  input  logic [RGB_W-1:0]  hue_rem_i,
  input  logic [RGB_W-1:0]  hue_div_i,
  input  logic [NumW-1:0]   hue_num_i,
  input  logic [RGB_W-1:0]  sat_rem_i,
  input  logic [RGB_W-1:0]  sat_div_i,
  input  logic [NumW-1:0]   sat_num_i,
  output logic              valid_o,
  input  logic              ready_i,
  output logic [RGB_W-1:0]  hue_rem_o,
  output logic [RGB_W-1:0]  hue_div_o,
  output logic [NumW-1:0]   hue_num_o,
  output logic [RGB_W-1:0]  sat_rem_o,
  output logic [RGB_W-1:0]  sat_div_o,
  output logic [NumW-1:0]   sat_num_o
);

  logic             valid_q;
  logic [RGB_W-1:0] hue_rem_q, hue_rem_d, hue_div_q;
  logic [NumW-1:0]  hue_num_q, hue_num_d;
  logic [RGB_W-1:0] sat_rem_q, sat_rem_d, sat_div_q;
  logic [NumW-1:0]  sat_num_q, sat_num_d;

  logic [RGB_W:0]   hue_part, hue_sub, sat_part, sat_sub;
  logic             hue_ge, sat_ge;

  always_comb begin
    // bring down the next dividend bit, quotient bit shifts in at the bottom
    hue_part  = {hue_rem_i, hue_num_i[NumW-1]};
    hue_ge    = hue_part >= {1'b0, hue_div_i};
    hue_sub   = hue_part - {1'b0, hue_div_i};
    hue_rem_d = hue_ge ? hue_sub[RGB_W-1:0] : hue_part[RGB_W-1:0];
    hue_num_d = {hue_num_i[NumW-2:0], hue_ge};

    sat_part  = {sat_rem_i, sat_num_i[NumW-1]};
    sat_ge    = sat_part >= {1'b0, sat_div_i};
    sat_sub   = sat_part - {1'b0, sat_div_i};
    sat_rem_d = sat_ge ? sat_sub[RGB_W-1:0] : sat_part[RGB_W-1:0];
    sat_num_d = {sat_num_i[NumW-2:0], sat_ge};
  end

  assign ready_o = !valid_q || ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i && ready_o) begin
      hue_rem_q <= hue_rem_d;
      hue_div_q <= hue_div_i;
      hue_num_q <= hue_num_d;
      sat_rem_q <= sat_rem_d;
      sat_div_q <= sat_div_i;
      sat_num_q <= sat_num_d;
    end
  end

  assign valid_o   = valid_q;
  assign hue_rem_o = hue_rem_q;
  assign hue_div_o = hue_div_q;
  assign hue_num_o = hue_num_q;
  assign sat_rem_o = sat_rem_q;
  assign sat_div_o = sat_div_q;
  assign sat_num_o = sat_num_q;

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// self-checking bench for the rgb to hsv pixel converter
// ----------------------------------------------------------------------------
// a directed table of corner pixels (black, white, primaries, ties, wrap of
// negative hue) is streamed first, then randomly shaped pixels. every item
// accepted at the input is predicted in order and each item leaving the
// output is checked field by field against the oldest prediction. both
// sides idle in random bursts, and once the output holds off long enough for
// the pipeline to fill and stall the input.
// ----------------------------------------------------------------------------
module testbench;
  import rhsv_pkg::*;

  localparam int unsigned RANDOM_PIXELS   = 900;
  localparam int unsigned HOLD_OFF_CYCLES = 100;
  localparam int unsigned DRAIN_CYCLES    = 50;
  localparam int unsigned WATCHDOG_LIMIT  = 2000;

  typedef struct packed {
    logic [RGB_W-1:0] red;
    logic [RGB_W-1:0] green;
    logic [RGB_W-1:0] blue;
  } rgb_t;

  typedef struct packed {
    logic [HUE_W-1:0] hue_q6;
    logic [SAT_W-1:0] saturation_q12;
    logic [VAL_W-1:0] value_max;
  } hsv_t;

  typedef struct packed {
    rgb_t pix;
    bit   typed;
    hsv_t hsv;
  } pixel_row_t;

  logic             clk_i;
  logic             rst_ni;
  logic             in_valid_i;
  logic             in_ready_o;
  logic [RGB_W-1:0] red_i;
  logic [RGB_W-1:0] green_i;
  logic [RGB_W-1:0] blue_i;
  logic             out_valid_o;
  logic             out_ready_i;
  logic [HUE_W-1:0] hue_q6_o;
  logic [SAT_W-1:0] saturation_q12_o;
  logic [VAL_W-1:0] value_max_o;

  pixel_row_t corner_rows[$];
  hsv_t       pending_hsv[$];
  bit         cur_typed;
  hsv_t       cur_hsv;
  bit         idle_on;
  bit         hold_off_req;
  int         errors = 0;
  int         quiet_cycles = 0;

  rgb_to_hsv_pixel DUT (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .red_i           (red_i),
    .green_i         (green_i),
    .blue_i          (blue_i),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .hue_q6_o        (hue_q6_o),
    .saturation_q12_o(saturation_q12_o),
    .value_max_o     (value_max_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  function automatic hsv_t predict_hsv(input rgb_t p);
    int r, g, b, mx, mn, d, num;
    hsv_t res;
    r = p.red;
    g = p.green;
    b = p.blue;
    mx = r;
    mn = r;
    if (g > mx) mx = g;
    if (b > mx) mx = b;
    if (g < mn) mn = g;
    if (b < mn) mn = b;
    d = mx - mn;
    // dominant channel picked red, green, blue; earlier one wins a tie
    if (d == 0) begin
      res.hue_q6 = '0;
    end else begin
      if (r >= g && r >= b) num = 60 * (g - b);
      else if (g >= r && g >= b) num = 60 * (2 * d + (b - r));
      else num = 60 * (4 * d + (r - g));
      if (num < 0) num += 360 * d;
      res.hue_q6 = HUE_W'((num << HUE_FRAC_BITS_DEF) / d);
    end
    res.saturation_q12 = (mx == 0) ? '0 : SAT_W'((d << SAT_FRAC_BITS_DEF) / mx);
    res.value_max = VAL_W'(mx);
    return res;
  endfunction

  task automatic add_row(input int r, input int g, input int b, input bit typed,
                         input int hue, input int sat, input int val);
    pixel_row_t row;
    row.pix   = '{red: RGB_W'(r), green: RGB_W'(g), blue: RGB_W'(b)};
    row.typed = typed;
    row.hsv   = '{hue_q6: HUE_W'(hue), saturation_q12: SAT_W'(sat),
                  value_max: VAL_W'(val)};
    corner_rows.push_back(row);
  endtask

  // one item offered at the falling edge, held until accepted
  task automatic send_pixel(input rgb_t p, input bit typed, input hsv_t hsv);
    int gap;
    @(negedge clk_i);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      in_valid_i <= 1'b0;
      gap = $urandom_range(1, 5);
      repeat (gap) @(negedge clk_i);
    end
    red_i      <= p.red;
    green_i    <= p.green;
    blue_i     <= p.blue;
    cur_typed  <= typed;
    cur_hsv    <= hsv;
    in_valid_i <= 1'b1;
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  // receiver side
  initial begin
    int gap;
    out_ready_i = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        out_ready_i <= 1'b0;
        repeat (HOLD_OFF_CYCLES) @(negedge clk_i);
        out_ready_i <= 1'b1;
      end else if (idle_on && $urandom_range(0, 3) == 0) begin
        out_ready_i <= 1'b0;
        gap = $urandom_range(1, 5);
        repeat (gap) @(negedge clk_i);
        out_ready_i <= 1'b1;
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  // prediction on input handshakes, checking on output handshakes
  always @(posedge clk_i) begin
    hsv_t want;
    if (rst_ni) begin
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
        quiet_cycles <= 0;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
      if (in_valid_i && in_ready_o) begin
        pending_hsv.push_back(cur_typed ? cur_hsv
                              : predict_hsv('{red: red_i, green: green_i, blue: blue_i}));
      end
      if (out_valid_o && out_ready_i) begin
        if (pending_hsv.size() == 0) begin
          errors++;
          $display("%0t: unexpected item hue %0d sat %0d val %0d", $time,
                   hue_q6_o, saturation_q12_o, value_max_o);
        end else begin
          want = pending_hsv.pop_front();
          if (hue_q6_o !== want.hue_q6) begin
            errors++;
            $display("%0t: hue_q6 expected %0d actual %0d", $time,
                     want.hue_q6, hue_q6_o);
          end
          if (saturation_q12_o !== want.saturation_q12) begin
            errors++;
            $display("%0t: saturation_q12 expected %0d actual %0d", $time,
                     want.saturation_q12, saturation_q12_o);
          end
          if (value_max_o !== want.value_max) begin
            errors++;
            $display("%0t: value_max expected %0d actual %0d", $time,
                     want.value_max, value_max_o);
          end
        end
      end
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("%0t: no handshake for %0d cycles", $time, WATCHDOG_LIMIT);
        $display("testbench: errors");
        $finish;
      end
    end
  end

  initial begin
    rgb_t p;
    int   v;
    int   k;
    rst_ni       = 1'b0;
    in_valid_i   = 1'b0;
    red_i        = '0;
    green_i      = '0;
    blue_i       = '0;
    cur_typed    = 1'b0;
    cur_hsv      = '0;
    idle_on      = 1'b1;
    hold_off_req = 1'b0;

    // corner pixels; hue in degrees times 64
    add_row(  0,   0,   0, 1,     0,    0,   0);  // black
    add_row(255, 255, 255, 1,     0,    0, 255);  // white
    add_row(255,   0,   0, 1,     0, 4096, 255);  // red
    add_row(  0, 255,   0, 1,  7680, 4096, 255);  // green
    add_row(  0,   0, 255, 1, 15360, 4096, 255);  // blue
    add_row(255, 255,   0, 1,  3840, 4096, 255);  // yellow, red wins the tie
    add_row(  0, 255, 255, 1, 11520, 4096, 255);  // cyan, green wins the tie
    add_row(255,   0, 255, 1, 19200, 4096, 255);  // magenta, negative hue wraps
    add_row(  1,   0,   0, 1,     0, 4096,   1);
    add_row(  1,   1,   1, 0,     0,    0,   0);  // smallest grey
    add_row(128, 128, 128, 0,     0,    0,   0);
    add_row(255,   0,   1, 0,     0,    0,   0);  // hue just under 360
    add_row(255,   1,   0, 0,     0,    0,   0);
    add_row(  0,   1,   0, 0,     0,    0,   0);
    add_row(  0,   0,   1, 0,     0,    0,   0);
    add_row(  1,   0, 255, 0,     0,    0,   0);
    add_row(254, 255, 253, 0,     0,    0,   0);
    add_row(200, 100,  50, 0,     0,    0,   0);
    add_row( 50, 100, 200, 0,     0,    0,   0);
    add_row( 10, 200,  20, 0,     0,    0,   0);
    add_row(128, 127,   1, 0,     0,    0,   0);
    add_row( 85, 170, 255, 0,     0,    0,   0);

    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    foreach (corner_rows[i])
      send_pixel(corner_rows[i].pix, corner_rows[i].typed, corner_rows[i].hsv);

    for (int i = 0; i < RANDOM_PIXELS; i++) begin
      // idling in segments, none in the last stretch
      if (i % 100 == 0) idle_on = (i < RANDOM_PIXELS - 100) && ($urandom_range(0, 3) != 0);
      if (i == 150) hold_off_req = 1'b1;
      case ($urandom_range(0, 9))
        0: begin
          v = $urandom_range(0, 255);
          p = '{red: RGB_W'(v), green: RGB_W'(v), blue: RGB_W'(v)};
        end
        1: begin
          // two channels are set to the same value, the third stays random
          v = $urandom_range(0, 255);
          p = '{red: RGB_W'($urandom), green: RGB_W'($urandom), blue: RGB_W'($urandom)};
          k = $urandom_range(0, 2);
          if (k != 0) p.red = RGB_W'(v);
          if (k != 1) p.green = RGB_W'(v);
          if (k != 2) p.blue = RGB_W'(v);
        end
        2: begin
          p = '{red: RGB_W'($urandom), green: RGB_W'($urandom), blue: RGB_W'($urandom)};
          k = $urandom_range(0, 2);
          if (k == 0) p.red = '0;
          else if (k == 1) p.green = '0;
          else p.blue = '0;
        end
        3: begin
          p.red   = ($urandom_range(0, 1) ? 8'd255 : 8'd0) ^ RGB_W'($urandom_range(0, 1));
          p.green = ($urandom_range(0, 1) ? 8'd255 : 8'd0) ^ RGB_W'($urandom_range(0, 1));
          p.blue  = ($urandom_range(0, 1) ? 8'd255 : 8'd0) ^ RGB_W'($urandom_range(0, 1));
        end
        default: begin
          p = '{red: RGB_W'($urandom), green: RGB_W'($urandom), blue: RGB_W'($urandom)};
        end
      endcase
      send_pixel(p, 1'b0, '0);
    end

    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (pending_hsv.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (errors == 0) begin
      $display("testbench: clean");
    end else begin
      $display("testbench: errors");
    end
    $finish;
  end

endmodule
